// ===== rtl/core/fcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fcp_pkg;
  localparam int NumCoefs = 24;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
  typedef struct packed {
    logic        command;
    logic [4:0]  coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
    logic signed [31:0] z_min;
    logic signed [31:0] z_max;
    logic [4:0]  block_level;
  } fcp_in_t;
  typedef struct packed {
    logic [16:0] coverage;
    logic signed [31:0] near_distance;
    logic [31:0] priority_res;
    logic        culled;
    logic        priority_saturated;
  } fcp_out_t;
endpackage
`default_nettype wire

// ===== rtl/core/fcp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fcp_in_if import fcp_pkg::*; ();
  logic    valid;
  logic    ready;
  fcp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
interface fcp_out_if import fcp_pkg::*; ();
  logic     valid;
  logic     ready;
  fcp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/frustum_coverage_priority_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Dir | Word
// in_ch     | in  | fcp_in_t: load (command 0) or evaluate (command 1)
// out_ch    | out | fcp_out_t: one word per evaluate, none per load
//
// Pipeline: one word per cycle while out_ch is not stalled; an evaluate word
// reaches out_ch through the datapath stages (sqrt and the bit-serial divides
// each take one stage per bit).
// Loads update the plane file on acceptance and leave the pipe empty. Plane
// terms are latched in the stage behind stage A, so a later load never
// reaches an earlier evaluate.
// rst clears the plane file, all stage valid bits and the output valid bit.
// A stall at out_ch freezes every stage; nothing is dropped or repeated.
module frustum_coverage_priority_unit import fcp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  fcp_in_if.sink   in_ch,
  fcp_out_if.source out_ch
);
  // Behavioural note: the evaluate path is computed as a registered
  // sequence of stages. Stage count is fixed so all valid bits advance
  // together under a single enable.
  localparam int SqStages  = 33;   // one root bit per stage
  localparam int DivStages = 16;   // coverage quotient bits
  localparam int PriStages = 41;   // priority quotient bits (cov^2*256 < 2^41)
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic signed [31:0] coefs [NumCoefs];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCoefs; i++) coefs[i] <= '0;
    end else if (in_ch.valid && adv && in_ch.data.command == CMD_LOAD &&
                 in_ch.data.coef_index < 5'(NumCoefs)) begin
      coefs[in_ch.data.coef_index] <= in_ch.data.coef_value;
    end
  end

  // ---- stage A: extents, centres, sum of squares ------------------------
  logic        a_v;
  logic        a_ok;
  logic [4:0]  a_lvl;
  logic signed [31:0] a_c [3];
  logic [65:0] a_sum;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_ch.valid && in_ch.data.command == CMD_EVAL;
  end
  always_ff @(posedge clk) begin
    logic signed [32:0] lo3 [3];
    logic signed [32:0] hi3 [3];
    logic [32:0] e;
    logic [65:0] s;
    logic ok;
    if (adv) begin
      lo3[0] = 33'(in_ch.data.x_min); hi3[0] = 33'(in_ch.data.x_max);
      lo3[1] = 33'(in_ch.data.y_min); hi3[1] = 33'(in_ch.data.y_max);
      lo3[2] = 33'(in_ch.data.z_min); hi3[2] = 33'(in_ch.data.z_max);
      s = '0; ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (hi3[i] < lo3[i]) ok = 1'b0;
        e = 33'(hi3[i] - lo3[i]);
        s = s + 66'(e) * 66'(e);
        a_c[i] <= 32'((lo3[i] + hi3[i]) >>> 1);
      end
      a_ok <= ok; a_sum <= s; a_lvl <= in_ch.data.block_level;
    end
  end

  // ---- plane products (registered), then sums ---------------------------
  // Every plane coefficient is captured here, in the stage behind stage A.
  logic        p_v, p_ok;
  logic [4:0]  p_lvl;
  logic [65:0] p_sum;
  logic signed [47:0] p_pr [6][3];
  logic signed [31:0] p_dc [6];
  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (adv) p_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ok <= a_ok; p_lvl <= a_lvl; p_sum <= a_sum;
      for (int i = 0; i < 6; i++) begin
        p_dc[i] <= coefs[i*4+3];
        for (int k = 0; k < 3; k++)
          p_pr[i][k] <= 48'((64'(coefs[i*4+k]) * 64'(a_c[k])) >>> 16);
      end
    end
  end
  logic        d_v, d_ok;
  logic [4:0]  d_lvl;
  logic [65:0] d_sum;
  logic signed [49:0] d_d [6];
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= p_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_ok <= p_ok; d_lvl <= p_lvl; d_sum <= p_sum;
      for (int i = 0; i < 6; i++)
        d_d[i] <= 50'(p_pr[i][0]) + 50'(p_pr[i][1]) + 50'(p_pr[i][2])
                  + 50'(p_dc[i]);
    end
  end

  // ---- square root, one bit per stage -----------------------------------
  logic        q_v   [SqStages+1];
  logic        q_ok  [SqStages+1];
  logic [4:0]  q_lvl [SqStages+1];
  logic signed [49:0] q_d [SqStages+1][6];
  logic [65:0] q_x   [SqStages+1];
  logic [34:0] q_rem [SqStages+1];
  logic [32:0] q_root[SqStages+1];
  always_comb begin
    q_v[0] = d_v; q_ok[0] = d_ok; q_lvl[0] = d_lvl; q_d[0] = d_d;
    q_x[0] = d_sum; q_rem[0] = '0; q_root[0] = '0;
  end
  for (genvar g = 0; g < SqStages; g++) begin : g_sq
    logic [34:0] r, t;
    always_comb begin
      r = {q_rem[g][32:0], q_x[g][65:64]};
      t = {q_root[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) q_v[g+1] <= 1'b0;
      else if (adv) q_v[g+1] <= q_v[g];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        q_ok[g+1] <= q_ok[g]; q_lvl[g+1] <= q_lvl[g]; q_d[g+1] <= q_d[g];
        q_x[g+1] <= {q_x[g][63:0], 2'b00};
        if (r >= t) begin
          q_rem[g+1] <= r - t; q_root[g+1] <= {q_root[g][31:0], 1'b1};
        end else begin
          q_rem[g+1] <= r; q_root[g+1] <= {q_root[g][31:0], 1'b0};
        end
      end
    end
  end

  // ---- culling, slice sizes ---------------------------------------------
  logic        c_v, c_cul, c_zero;
  logic [4:0]  c_lvl;
  logic signed [49:0] c_dist;
  logic signed [51:0] c_pw, c_ph, c_fw, c_fh;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= q_v[SqStages];
  end
  always_ff @(posedge clk) begin
    logic cul;
    logic [2:0] first;
    logic signed [51:0] sb [4];
    logic signed [51:0] fw, fh, pw, ph;
    logic signed [51:0] rad;
    if (adv) begin
      rad = 52'(q_root[SqStages][32:1]);
      cul = 1'b0; first = 3'd7;
      for (int i = 5; i >= 0; i--)
        if (52'(q_d[SqStages][i]) < -rad) begin cul = 1'b1; first = 3'(i); end
      for (int i = 0; i < 4; i++) sb[i] = 52'(q_d[SqStages][i]) - rad;
      fw = sb[0] + sb[1] + rad + rad;
      fh = sb[2] + sb[3] + rad + rad;
      pw = fw - (sb[0] > 0 ? sb[0] : 52'sd0) - (sb[1] > 0 ? sb[1] : 52'sd0);
      ph = fh - (sb[2] > 0 ? sb[2] : 52'sd0) - (sb[3] > 0 ? sb[3] : 52'sd0);
      c_cul <= !q_ok[SqStages] || cul;
      c_dist <= (!q_ok[SqStages] || (cul && first != 3'd5)) ? 50'sd0 :
                q_d[SqStages][4];
      c_zero <= fw == 0 || fh == 0 || pw == 0 || ph == 0 ||
                ((pw < 0) ^ (ph < 0) ^ (fw < 0) ^ (fh < 0));
      c_pw <= pw < 0 ? -pw : pw; c_ph <= ph < 0 ? -ph : ph;
      c_fw <= fw < 0 ? -fw : fw; c_fh <= fh < 0 ? -fh : fh;
      c_lvl <= q_lvl[SqStages];
    end
  end

  // ---- wide products cut into 26x26 partials over two stages ------------
  logic        m_v, m_cul, m_zero;
  logic [4:0]  m_lvl;
  logic signed [49:0] m_dist;
  logic [51:0] m_n [4];
  logic [51:0] m_d [4];
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (adv) m_v <= c_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_cul <= c_cul; m_zero <= c_zero; m_lvl <= c_lvl; m_dist <= c_dist;
      m_n[0] <= 52'(c_pw[25:0]) * 52'(c_ph[25:0]);
      m_n[1] <= 52'(c_pw[25:0]) * 52'(c_ph[51:26]);
      m_n[2] <= 52'(c_pw[51:26]) * 52'(c_ph[25:0]);
      m_n[3] <= 52'(c_pw[51:26]) * 52'(c_ph[51:26]);
      m_d[0] <= 52'(c_fw[25:0]) * 52'(c_fh[25:0]);
      m_d[1] <= 52'(c_fw[25:0]) * 52'(c_fh[51:26]);
      m_d[2] <= 52'(c_fw[51:26]) * 52'(c_fh[25:0]);
      m_d[3] <= 52'(c_fw[51:26]) * 52'(c_fh[51:26]);
    end
  end
  logic        n_v, n_cul, n_skip;
  logic [4:0]  n_lvl;
  logic signed [49:0] n_dist;
  logic [103:0] n_num, n_den;
  always_ff @(posedge clk) begin
    if (rst) n_v <= 1'b0;
    else if (adv) n_v <= m_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_cul <= m_cul; n_skip <= m_cul || m_zero; n_lvl <= m_lvl;
      n_dist <= m_dist;
      n_num <= 104'(m_n[0]) + (104'(m_n[1]) << 26) + (104'(m_n[2]) << 26)
               + (104'(m_n[3]) << 52);
      n_den <= 104'(m_d[0]) + (104'(m_d[1]) << 26) + (104'(m_d[2]) << 26)
               + (104'(m_d[3]) << 52);
    end
  end

  // ---- coverage quotient, restoring divide one bit per stage ------------
  logic        v_v   [DivStages+1];
  logic        v_cul [DivStages+1];
  logic        v_full[DivStages+1];
  logic        v_skip[DivStages+1];
  logic [4:0]  v_lvl [DivStages+1];
  logic signed [49:0] v_dist [DivStages+1];
  logic [103:0] v_den [DivStages+1];
  logic [104:0] v_rem [DivStages+1];
  logic [15:0] v_q   [DivStages+1];
  always_comb begin
    v_v[0] = n_v; v_cul[0] = n_cul; v_skip[0] = n_skip; v_lvl[0] = n_lvl;
    v_dist[0] = n_dist; v_den[0] = n_den; v_rem[0] = 105'(n_num);
    v_full[0] = n_num >= n_den; v_q[0] = '0;
  end
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [105:0] r2;
    assign r2 = {v_rem[g], 1'b0};
    always_ff @(posedge clk) begin
      if (rst) v_v[g+1] <= 1'b0;
      else if (adv) v_v[g+1] <= v_v[g];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        v_cul[g+1] <= v_cul[g]; v_full[g+1] <= v_full[g];
        v_skip[g+1] <= v_skip[g]; v_lvl[g+1] <= v_lvl[g];
        v_dist[g+1] <= v_dist[g]; v_den[g+1] <= v_den[g];
        if (r2 >= 106'(v_den[g])) begin
          v_rem[g+1] <= 105'(r2 - 106'(v_den[g]));
          v_q[g+1] <= {v_q[g][14:0], 1'b1};
        end else begin
          v_rem[g+1] <= 105'(r2);
          v_q[g+1] <= {v_q[g][14:0], 1'b0};
        end
      end
    end
  end

  // ---- priority setup ---------------------------------------------------
  logic        u_v, u_cul, u_neg;
  logic [16:0] u_cov;
  logic signed [49:0] u_dist;
  logic [50:0] u_den;
  always_ff @(posedge clk) begin
    if (rst) u_v <= 1'b0;
    else if (adv) u_v <= v_v[DivStages];
  end
  always_ff @(posedge clk) begin
    logic [10:0] l2;
    logic signed [51:0] dn;
    if (adv) begin
      l2 = 11'(v_lvl[DivStages]) * 11'(v_lvl[DivStages]) + 11'd1;
      dn = (52'(l2) <<< 16) + 52'(v_dist[DivStages]);
      u_cov <= v_skip[DivStages] ? 17'd0 :
               v_full[DivStages] ? 17'd65536 : 17'(v_q[DivStages]);
      u_neg <= dn <= 0; u_den <= 51'(dn);
      u_cul <= v_cul[DivStages]; u_dist <= v_dist[DivStages];
    end
  end
  logic        w_v, w_cul, w_neg;
  logic [16:0] w_cov;
  logic signed [49:0] w_dist;
  logic [50:0] w_den;
  logic [40:0] w_num;
  always_ff @(posedge clk) begin
    if (rst) w_v <= 1'b0;
    else if (adv) w_v <= u_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      w_cul <= u_cul; w_neg <= u_neg; w_cov <= u_cov;
      w_dist <= u_dist; w_den <= u_den;
      w_num <= {33'(34'(u_cov) * 34'(u_cov)), 8'd0};
    end
  end

  // ---- priority quotient, one bit per stage -----------------------------
  logic        t_v   [PriStages+1];
  logic        t_cul [PriStages+1];
  logic        t_neg [PriStages+1];
  logic [16:0] t_cov [PriStages+1];
  logic signed [49:0] t_dist [PriStages+1];
  logic [50:0] t_den [PriStages+1];
  logic [40:0] t_n   [PriStages+1];
  logic [51:0] t_rem [PriStages+1];
  logic [40:0] t_q   [PriStages+1];
  always_comb begin
    t_v[0] = w_v; t_cul[0] = w_cul; t_neg[0] = w_neg; t_cov[0] = w_cov;
    t_dist[0] = w_dist; t_den[0] = w_den; t_n[0] = w_num;
    t_rem[0] = '0; t_q[0] = '0;
  end
  for (genvar g = 0; g < PriStages; g++) begin : g_pri
    logic [52:0] r2;
    assign r2 = {t_rem[g], t_n[g][40]};
    always_ff @(posedge clk) begin
      if (rst) t_v[g+1] <= 1'b0;
      else if (adv) t_v[g+1] <= t_v[g];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        t_cul[g+1] <= t_cul[g]; t_neg[g+1] <= t_neg[g];
        t_cov[g+1] <= t_cov[g]; t_dist[g+1] <= t_dist[g];
        t_den[g+1] <= t_den[g]; t_n[g+1] <= {t_n[g][39:0], 1'b0};
        if (r2 >= 53'(t_den[g])) begin
          t_rem[g+1] <= 52'(r2 - 53'(t_den[g]));
          t_q[g+1] <= {t_q[g][39:0], 1'b1};
        end else begin
          t_rem[g+1] <= 52'(r2);
          t_q[g+1] <= {t_q[g][39:0], 1'b0};
        end
      end
    end
  end

  // ---- output register --------------------------------------------------
  always_ff @(posedge clk) begin
    logic sat;
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= t_v[PriStages];
      sat = t_neg[PriStages] || (t_q[PriStages][40:32] != '0);
      out_ch.data.coverage <= t_cov[PriStages];
      out_ch.data.priority_saturated <= sat;
      out_ch.data.priority_res <= sat ? 32'hFFFF_FFFF : t_q[PriStages][31:0];
      out_ch.data.culled <= t_cul[PriStages];
      out_ch.data.near_distance <=
        t_dist[PriStages] > 50'sd2147483647 ? 32'sh7FFF_FFFF :
        t_dist[PriStages] < -50'sd2147483648 ? 32'sh8000_0000 :
        32'(t_dist[PriStages]);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/fcp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fcp_checker import fcp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire fcp_out_t out_data
);
  a_cov_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.coverage <= 17'd65536) else $error("coverage range");
  a_cull_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.culled |-> out_data.coverage == '0)
    else $error("culled with coverage");
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.priority_saturated |-> out_data.priority_res == '1)
    else $error("saturation value");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled word changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready low with empty output");
endmodule
bind frustum_coverage_priority_unit fcp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
